// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 check failed");

// Consequent must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 check failed");

`endif

// File: hw/rtl/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  localparam logic [7:0] PadByte     = 8'h80;
  localparam logic [5:0] LenPos      = 6'd56;
  localparam logic [5:0] BlkLastByte = 6'd63;
  localparam logic [5:0] LastRound   = 6'd63;
  localparam logic [2:0] LastWord    = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_UPD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_PAD80,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_e;

  typedef struct packed {
    byte_sel_e   byte_sel;
    logic        shift_byte;
    logic        add_bits;
    logic        load_vars;
    logic        round_en;
    logic [5:0]  round_idx;
    logic        upd_hash;
    logic        out_rot;
    logic        hash_init;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] byte_cnt;
  } dp_stat_t;

  function automatic logic [31:0] hash_iv(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sha256_hash_core.sv
// Channel   Dir  tdata (low bit up)   tuser            tlast
// s_axis    in   [7:0] data_byte      [0] has_byte     end_of_message
// m_axis    out  [31:0] digest_word   [2:0] word_index last_word
//
// An item without a byte leaves the block as it is; a byte that completes a 64-byte
// block is followed by loading the round variables, 64 rounds on the single round
// unit and adding into the hash words.
// A message end shifts in one padding byte per cycle up to the block end, with
// one or two compressions, then offers eight digest items, one a cycle while m_axis is ready.
// Input is not taken while a block compresses, padding runs or the digest waits.
// Reset is asynchronous and active low and restores the initial hash value.
`timescale 1ns / 1ps
`default_nettype none

module sha256_hash_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] has_byte
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser_o,   // [2:0] word_index
  output logic             m_axis_tlast_o
);

  sha256_pkg::dp_cmd_t  cmd;
  sha256_pkg::dp_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  sha256_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (s_axis_tdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .digest_word_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sha256_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  input  wire logic                 s_axis_tuser_i,
  input  wire logic                 s_axis_tlast_i,
  output logic                      s_axis_tready_o,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [2:0]                m_axis_tuser_o,
  output logic                      m_axis_tlast_o,
  input  wire sha256_pkg::dp_stat_t stat_i,
  output sha256_pkg::dp_cmd_t       cmd_o
);

  sha256_pkg::state_e state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] word_q, word_d;
  logic       pad_q, pad_d;
  logic       seen80_q, seen80_d;
  logic       wrap_q, wrap_d;
  logic       final_q, final_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha256_pkg::ST_IDLE;
      rnd_q    <= '0;
      word_q   <= '0;
      pad_q    <= 1'b0;
      seen80_q <= 1'b0;
      wrap_q   <= 1'b0;
      final_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rnd_q    <= rnd_d;
      word_q   <= word_d;
      pad_q    <= pad_d;
      seen80_q <= seen80_d;
      wrap_q   <= wrap_d;
      final_q  <= final_d;
    end
  end

  assign m_axis_tuser_o = word_q;
  assign m_axis_tlast_o = (word_q == sha256_pkg::LastWord);

  always_comb begin
    logic is_len;
    is_len          = 1'b0;
    state_d         = state_q;
    rnd_d           = rnd_q;
    word_d          = word_q;
    pad_d           = pad_q;
    seen80_d        = seen80_q;
    wrap_d          = wrap_q;
    final_d         = final_q;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    cmd_o           = '0;
    cmd_o.byte_sel  = sha256_pkg::BSEL_DATA;
    cmd_o.round_idx = rnd_q;

    case (state_q)
      sha256_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i) begin
            cmd_o.shift_byte = 1'b1;
            cmd_o.add_bits   = 1'b1;
          end
          // A byte that fills the block is compressed before any padding starts.
          if (s_axis_tuser_i && (stat_i.byte_cnt == sha256_pkg::BlkLastByte)) begin
            state_d  = sha256_pkg::ST_LOAD;
            pad_d    = s_axis_tlast_i;
            seen80_d = 1'b0;
            wrap_d   = 1'b0;
            final_d  = 1'b0;
          end else if (s_axis_tlast_i) begin
            state_d  = sha256_pkg::ST_PAD;
            pad_d    = 1'b1;
            seen80_d = 1'b0;
            wrap_d   = 1'b0;
            final_d  = 1'b0;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        cmd_o.shift_byte = 1'b1;
        if (!seen80_q) begin
          cmd_o.byte_sel = sha256_pkg::BSEL_PAD80;
          seen80_d       = 1'b1;
          // With no room left for the length, a second block is needed.
          wrap_d = (stat_i.byte_cnt >= sha256_pkg::LenPos) &&
                   (stat_i.byte_cnt != sha256_pkg::BlkLastByte);
        end else if (!wrap_q && (stat_i.byte_cnt >= sha256_pkg::LenPos)) begin
          cmd_o.byte_sel = sha256_pkg::BSEL_LEN;
          is_len         = 1'b1;
        end else begin
          cmd_o.byte_sel = sha256_pkg::BSEL_ZERO;
        end
        if (stat_i.byte_cnt == sha256_pkg::BlkLastByte) begin
          state_d = sha256_pkg::ST_LOAD;
          wrap_d  = 1'b0;
          final_d = is_len;
        end
      end
      sha256_pkg::ST_LOAD: begin
        cmd_o.load_vars = 1'b1;
        rnd_d           = '0;
        state_d         = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d          = rnd_q + 6'd1;
        if (rnd_q == sha256_pkg::LastRound) begin
          state_d = sha256_pkg::ST_UPD;
        end
      end
      sha256_pkg::ST_UPD: begin
        cmd_o.upd_hash = 1'b1;
        if (final_q) begin
          state_d = sha256_pkg::ST_OUT;
          word_d  = '0;
        end else if (pad_q) begin
          state_d = sha256_pkg::ST_PAD;
        end else begin
          state_d = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          cmd_o.out_rot = 1'b1;
          word_d        = word_q + 3'd1;
          if (word_q == sha256_pkg::LastWord) begin
            cmd_o.hash_init = 1'b1;
            state_d         = sha256_pkg::ST_IDLE;
            pad_d           = 1'b0;
            seen80_d        = 1'b0;
            final_d         = 1'b0;
          end
        end
      end
      default: begin
        state_d = sha256_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sha256_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          data_byte_i,
  input  wire sha256_pkg::dp_cmd_t cmd_i,
  output sha256_pkg::dp_stat_t     stat_o,
  output logic [31:0]              digest_word_o
);

  // The block is a byte-wide shift line while filling and a word-wide
  // schedule window while compressing; word 0 sits in the top bits.
  logic [511:0] blk_q;
  logic [31:0]  hash_q [8];
  logic [31:0]  vars_q [8];
  logic [5:0]   cnt_q;
  logic [63:0]  bits_q;

  logic [7:0]   byte_d;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2, ch, maj;

  assign stat_o.byte_cnt = cnt_q;
  assign digest_word_o   = hash_q[0];

  always_comb begin
    case (cmd_i.byte_sel)
      sha256_pkg::BSEL_DATA:  byte_d = data_byte_i;
      sha256_pkg::BSEL_PAD80: byte_d = sha256_pkg::PadByte;
      sha256_pkg::BSEL_LEN:   byte_d = bits_q[63:56];
      default:                byte_d = 8'h00;
    endcase
  end

  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];
  assign w_new = sha256_pkg::sml_sig1(w14) + w9 + sha256_pkg::sml_sig0(w1) + w0;

  assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1  = vars_q[7] + sha256_pkg::big_sig1(vars_q[4]) + ch +
               sha256_pkg::round_k(cmd_i.round_idx) + w0;
  assign t2  = sha256_pkg::big_sig0(vars_q[0]) + maj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      bits_q <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= sha256_pkg::hash_iv(3'(i));
      end
    end else begin
      if (cmd_i.shift_byte) begin
        cnt_q <= cnt_q + 6'd1;
      end
      if (cmd_i.add_bits) begin
        bits_q <= bits_q + 64'd8;
      end else if (cmd_i.shift_byte && (cmd_i.byte_sel == sha256_pkg::BSEL_LEN)) begin
        // Shifting the length out leaves it cleared for the next message.
        bits_q <= {bits_q[55:0], 8'h00};
      end
      if (cmd_i.hash_init) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= sha256_pkg::hash_iv(3'(i));
        end
      end else if (cmd_i.upd_hash) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + vars_q[i];
        end
      end else if (cmd_i.out_rot) begin
        for (int i = 0; i < 7; i++) begin
          hash_q[i] <= hash_q[i+1];
        end
        hash_q[7] <= hash_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_byte) begin
      blk_q <= {blk_q[503:0], byte_d};
    end else if (cmd_i.round_en) begin
      blk_q <= {blk_q[479:0], w_new};
    end
    if (cmd_i.load_vars) begin
      for (int i = 0; i < 8; i++) begin
        vars_q[i] <= hash_q[i];
      end
    end else if (cmd_i.round_en) begin
      vars_q[0] <= t1 + t2;
      vars_q[1] <= vars_q[0];
      vars_q[2] <= vars_q[1];
      vars_q[3] <= vars_q[2];
      vars_q[4] <= vars_q[3] + t1;
      vars_q[5] <= vars_q[4];
      vars_q[6] <= vars_q[5];
      vars_q[7] <= vars_q[6];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sha256_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sha256_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        s_axis_tlast_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic [2:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // The digest is only offered while no input is being taken.
  `SHA_ASSERT_SAME(a_out_blocks_in, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o)

  // A message end always leads to padding, so input is not taken in the cycle after it.
  `SHA_ASSERT_NEXT(a_end_stalls_in, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, !s_axis_tready_o)

  // Digest words follow each other in index order without a gap.
  `SHA_ASSERT_NEXT(a_word_order, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o && (m_axis_tuser_o == ($past(m_axis_tuser_o) + 3'd1)))

  // After the final word the output channel falls idle.
  `SHA_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, !m_axis_tvalid_o)

  // A stalled digest item holds its value.
  `SHA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

endmodule

bind sha256_hash_core sha256_chk u_sha256_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [0:63][31:0] RND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam int         LEN_OFFSET = 56;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        s_axis_tuser_i = 1'b0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tready_i = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Predictor state.
  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  logic [5:0]  block_fill;
  logic [63:0] bit_count;

  digest_word_t digest_q [$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          items_sent = 0;
  int          error_count = 0;

  sha256_hash_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
    block_fill = '0;
    bit_count  = '0;
  endfunction

  function automatic void mix_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[t] + w[t];
      s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  // Applies one accepted item; a message end queues the eight digest words.
  function automatic void hash_item(input logic [7:0] data, input logic has, input logic fin);
    int           pos;
    digest_word_t dw;
    if (has) begin
      block_bytes[block_fill] = data;
      bit_count  = bit_count + 64'd8;
      block_fill = block_fill + 6'd1;
      if (block_fill == 6'd0) mix_block();
    end
    if (fin) begin
      pos = int'(block_fill);
      block_bytes[pos] = PAD_MARK;
      for (int i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
      // No room left for the length, so it goes into an extra block.
      if (pos >= LEN_OFFSET) begin
        mix_block();
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      end
      for (int k = 0; k < 8; k++) block_bytes[LEN_OFFSET + k] = bit_count[63 - 8*k -: 8];
      mix_block();
      for (int k = 0; k < 8; k++) begin
        dw.word  = hash_state[k];
        dw.index = k[2:0];
        dw.last  = (k == 7);
        digest_q.push_back(dw);
      end
      restart_hash();
    end
  endfunction

  always @(posedge clk_i) begin : check_digest
    digest_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest item: digest_word %h word_index %0d last_word %b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        error_count++;
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata_o !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, m_axis_tdata_o);
          error_count++;
        end
        if (m_axis_tuser_o !== want.index) begin
          $error("word_index: expected %0d, got %0d", want.index, m_axis_tuser_o);
          error_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_word: expected %b, got %b", want.last, m_axis_tlast_o);
          error_count++;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [7:0] data, input logic has, input logic fin);
    items_sent++;
    if ($urandom_range(99, 0) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99, 0) < sender_idle_pct) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= has;
    s_axis_tlast_i  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    hash_item(data, has, fin);
    @(negedge clk_i);
  endtask

  // The byte count is capped to the items left in the phase; mixed-in items without a byte can overrun it.
  task automatic send_random_message(input int budget);
    int   len;
    int   pick;
    logic end_on_byte;
    pick = $urandom_range(99, 0);
    if (pick < 75) len = $urandom_range(12, 0);
    else if (pick < 95) len = $urandom_range(66, 52);
    else len = $urandom_range(130, 116);
    if (len > budget - 1) len = budget - 1;
    end_on_byte = (len != 0) && ($urandom_range(1, 0) == 1);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(9, 0) == 0) send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255, 0)), 1'b1, end_on_byte && (n == len - 1));
    end
    if (!end_on_byte) send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1);
  endtask

  task automatic test_empty_message();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
  endtask

  task automatic test_byte_with_end();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
  endtask

  task automatic test_pause_until_drained();
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'h34, 1'b1, 1'b0);
    send_item(8'h56, 1'b1, 1'b1);
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (digest_q.size() != 0);
    send_item(8'hab, 1'b1, 1'b0);
    send_item(8'hcd, 1'b0, 1'b1);
  endtask

  task automatic test_random_phase(input int count, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    int target;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    target = items_sent + count;
    while (items_sent < target) send_random_message(target - items_sent);
  endtask

  initial begin
    restart_hash();
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_message();
    test_byte_with_end();
    test_field_extremes();
    test_pause_until_drained();
    test_random_phase(70, 0, 0);
    test_random_phase(60, 83, 0);
    test_random_phase(60, 0, 83);
    test_random_phase(60, 30, 30);
    s_axis_tvalid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (error_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

// File: sha256_hash_core.f
+incdir+hw/rtl
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_dp.sv
hw/rtl/sha256_hash_core.sv
hw/rtl/sha256_chk.sv
tb/testbench.sv
